// ===== design/refcounted_page_frame_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// refcounted page frame allocator assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define RPFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpfa_pkg
// shared types, codes and constants of the page frame allocator
// ----------------------------------------------------------------------------
package rpfa_pkg;

  localparam int PAGE_BITS      = 12;
  localparam int CNT_FIELD_BITS = 16;
  localparam int CFG_BITS       = 13;
  localparam int NUM_PAGES_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CFG_BITS-1:0] FIRST_RESET = 13'd0;
  localparam logic [CFG_BITS-1:0] END_RESET   = 13'd4096;

  // configuration register indexes
  localparam logic CFG_IDX_FIRST = 1'b0;
  localparam logic CFG_IDX_END   = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_INCREF = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PAGE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_COUNT   = 2'd3
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [PAGE_BITS-1:0] page;
  } in_t;

  typedef struct packed {
    status_t                   status;
    logic [PAGE_BITS-1:0]      page_out;
    logic [CNT_FIELD_BITS-1:0] ref_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic init_start;
    logic exec;
    logic sweep;
    logic sweep_push;
    logic hold_load;
    logic out_load;
    logic out_from_hold;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
  } stat_t;

endpackage

// ===== design/rpfa_ram.sv =====
// ----------------------------------------------------------------------------
// rpfa_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rpfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpfa_ctrl
// sequencer: clearing pass, accept, execute, init sweep and result hand-off
// ----------------------------------------------------------------------------
`include "refcounted_page_frame_allocator_defines.svh"

module rpfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rpfa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rpfa_pkg::cmd_t cmd,
  input  rpfa_pkg::stat_t stat
);

  import rpfa_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_INIT  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;
  logic   accept;

  assign can_load = !out_valid_r || !out_stall;
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.accept = accept;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_INIT) begin
            cmd.init_start = 1'b1;
            state_nxt      = S_INIT;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.hold_load = 1'b1;
          state_nxt     = S_HOLD;
        end
      end
      S_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_push = 1'b1;
        if (stat.sweep_last) begin
          if (can_load) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.hold_load = 1'b1;
            state_nxt     = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (can_load) begin
          cmd.out_load      = 1'b1;
          cmd.out_from_hold = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RPFA_ASSERT_NEXT(a_exec_follows, accept && (in_data.op != OP_INIT), state_r == S_EXEC, "op did not move to execute")
  `RPFA_ASSERT_NOW(a_hold_full, state_r == S_HOLD, out_valid_r, "hold entered with empty output")
  `RPFA_ASSERT_NOW(a_rise_src, $rose(out_valid_r), $past(state_r == S_EXEC || state_r == S_INIT || state_r == S_HOLD), "result from no source")

endmodule

// ===== design/rpfa_dp.sv =====
// ----------------------------------------------------------------------------
// rpfa_dp
// datapath: config registers, count and stack memories, stack pointer, results
// ----------------------------------------------------------------------------
`include "refcounted_page_frame_allocator_defines.svh"

module rpfa_dp #(
  parameter int NUM_PAGES  = rpfa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rpfa_pkg::CFG_BITS-1:0] cfg_wdata,
  input  rpfa_pkg::in_t                 in_data,
  input  rpfa_pkg::cmd_t                cmd,
  output rpfa_pkg::stat_t               stat,
  output rpfa_pkg::out_t                out_data
);

  import rpfa_pkg::*;

  localparam int PAGE_LIMIT = (NUM_PAGES < (2 ** PAGE_BITS)) ? NUM_PAGES : (2 ** PAGE_BITS);
  localparam int CAW = $clog2(PAGE_LIMIT);
  localparam int SAW = $clog2(NUM_PAGES);
  localparam int STW = $clog2(NUM_PAGES + 1);
  localparam logic [CFG_BITS-1:0] LIMIT_C = CFG_BITS'(PAGE_LIMIT);

  logic [CFG_BITS-1:0]   first_r, end_r;
  op_t                   op_r;
  logic [PAGE_BITS-1:0]  page_r;
  logic [STW-1:0]        stack_top_r, stack_top_nxt;
  logic [CAW-1:0]        sweep_cnt_r, sweep_cnt_nxt;
  out_t                  hold_r, out_r, res;

  logic [CFG_BITS-1:0]   lim;
  logic [STW-1:0]        top_dec;
  logic                  stack_full;
  logic                  sweep_in_range;
  logic                  page_managed;

  logic                  cnt_we;
  logic [CAW-1:0]        cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata, cnt_dec, cnt_inc;
  logic                  stk_we;
  logic [SAW-1:0]        stk_waddr;
  logic [PAGE_BITS-1:0]  stk_wdata, stk_rdata;

  assign lim            = (end_r < LIMIT_C) ? end_r : LIMIT_C;
  assign top_dec        = stack_top_r - 1'b1;
  assign stack_full     = (stack_top_r == STW'(NUM_PAGES));
  assign sweep_in_range = (CFG_BITS'(sweep_cnt_r) >= first_r) && (CFG_BITS'(sweep_cnt_r) < lim);
  assign page_managed   = ({1'b0, page_r} >= first_r) && ({1'b0, page_r} < lim);
  assign cnt_dec        = cnt_rdata - 1'b1;
  assign cnt_inc        = cnt_rdata + 1'b1;
  assign stat.sweep_last = (sweep_cnt_r == CAW'(PAGE_LIMIT - 1));

  rpfa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PAGE_LIMIT)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (in_data.page[CAW-1:0]),
    .rdata (cnt_rdata)
  );

  rpfa_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (top_dec[SAW-1:0]),
    .rdata (stk_rdata)
  );

  always_comb begin
    res           = '0;
    cnt_we        = 1'b0;
    cnt_waddr     = sweep_cnt_r;
    cnt_wdata     = '0;
    stk_we        = 1'b0;
    stk_waddr     = stack_top_r[SAW-1:0];
    stk_wdata     = PAGE_BITS'(sweep_cnt_r);
    stack_top_nxt = stack_top_r;
    sweep_cnt_nxt = sweep_cnt_r;
    if (cmd.init_start) begin
      stack_top_nxt = '0;
      sweep_cnt_nxt = '0;
    end
    // clearing pass / init sweep: one page per cycle
    if (cmd.sweep) begin
      cnt_we        = 1'b1;
      sweep_cnt_nxt = stat.sweep_last ? '0 : sweep_cnt_r + 1'b1;
      if (cmd.sweep_push && sweep_in_range && !stack_full) begin
        stk_we        = 1'b1;
        stack_top_nxt = stack_top_r + 1'b1;
      end
    end
    if (cmd.exec) begin
      res.page_out = page_r;
      unique case (op_r)
        OP_ALLOC: begin
          res.page_out = '0;
          if (stack_top_r == '0) begin
            res.status = ST_NO_PAGE;
          end else begin
            res.page_out  = stk_rdata;
            res.ref_count = CNT_FIELD_BITS'(1);
            stack_top_nxt = top_dec;
            cnt_waddr     = stk_rdata[CAW-1:0];
            cnt_wdata     = COUNT_BITS'(1);
            cnt_we        = ({1'b0, stk_rdata} < LIMIT_C);
          end
        end
        OP_FREE: begin
          if (!page_managed) begin
            res.status = ST_RANGE;
          end else if (cnt_rdata == '0) begin
            res.status = ST_COUNT;
          end else begin
            res.ref_count = CNT_FIELD_BITS'(cnt_dec);
            cnt_we        = 1'b1;
            cnt_waddr     = page_r[CAW-1:0];
            cnt_wdata     = cnt_dec;
            // last reference gone: back on the stack unless it is full
            if ((cnt_dec == '0) && !stack_full) begin
              stk_we        = 1'b1;
              stk_wdata     = page_r;
              stack_top_nxt = stack_top_r + 1'b1;
            end
          end
        end
        OP_INCREF: begin
          if ({1'b0, page_r} >= LIMIT_C) begin
            res.status = ST_RANGE;
          end else if (cnt_rdata == '1) begin
            res.status    = ST_COUNT;
            res.ref_count = CNT_FIELD_BITS'(cnt_rdata);
          end else begin
            res.ref_count = CNT_FIELD_BITS'(cnt_inc);
            cnt_we        = 1'b1;
            cnt_waddr     = page_r[CAW-1:0];
            cnt_wdata     = cnt_inc;
          end
        end
        OP_INIT: begin
          res.page_out = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= FIRST_RESET;
      end_r       <= END_RESET;
      stack_top_r <= '0;
      sweep_cnt_r <= '0;
    end else begin
      stack_top_r <= stack_top_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_FIRST: first_r <= cfg_wdata;
          CFG_IDX_END:   end_r   <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_data.op;
      page_r <= in_data.page;
    end
    if (cmd.hold_load) begin
      hold_r <= res;
    end
    if (cmd.out_load) begin
      out_r <= cmd.out_from_hold ? hold_r : res;
    end
  end

  assign out_data = out_r;

  `RPFA_ASSERT_NEXT(a_push_bumps_top, stk_we, stack_top_r == $past(stack_top_r) + 1, "push did not advance stack top")
  `RPFA_ASSERT_NEXT(a_pop_drops_top, cmd.exec && (op_r == OP_ALLOC) && (stack_top_r != '0), stack_top_r == $past(stack_top_r) - 1, "pop did not lower stack top")

endmodule

// ===== design/refcounted_page_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// page frame allocator with a lifo free stack and per-page reference counts
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   in_       input       in_valid / in_stall     in_data   (op, page)
//   out_      output      out_valid / out_stall   out_data  (status, page_out, ref_count)
//   cfg_      input       cfg_we                  cfg_index, cfg_wdata
//
// alloc, free and incref: the transfer cycle reads the count
//   and stack memories, the next cycle writes them back and forms the result
// init runs the sweep over the count memory
// after reset a clearing pass zeroes the counts;
//   in_stall stays high meanwhile, config writes are still taken
// one item at a time; a result waiting under out_stall does not block the next
//   transfer, which finishes into a hold register behind the output register
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator #(
  parameter int NUM_PAGES  = rpfa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rpfa_pkg::in_t                 in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output rpfa_pkg::out_t                out_data,
  // configuration writes
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rpfa_pkg::CFG_BITS-1:0] cfg_wdata
);

  import rpfa_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the handshakes and the output valid
  rpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: memories, stack pointer, bounds, result registers
  rpfa_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
